// File: hdl/ila_pkg.sv
// shared types and constants of the indicator light arbiter
// no dependencies; imported by the interfaces' users and every module
package ila_pkg;

  // one stored light request
  typedef struct packed {
    logic [31:0] color;
    logic [1:0]  mode;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [1:0]  bmode;
  } ila_req_t;

  // one result transaction
  typedef struct packed {
    logic        status;
    logic        apply;
    logic        target;
    logic        levels_valid;
    logic [11:0] backlight_level;
    logic [7:0]  white_level;
    logic [7:0]  blue_level;
    logic [7:0]  green_level;
    logic        breathe;
    logic [15:0] delay_on_ms;
    logic [15:0] delay_off_ms;
  } ila_res_t;

  // request to the shared multiply / divide-by-255 unit
  typedef struct packed {
    logic        start;
    logic        div_en;
    logic [7:0]  op_a;
    logic [11:0] op_b;
  } ila_mul_req_t;

  // response of the shared unit
  typedef struct packed {
    logic        done;
    logic [19:0] result;
  } ila_mul_rsp_t;

  localparam logic [1:0]  TYPE_BACKLIGHT = 2'd3;
  localparam logic [1:0]  FLASH_BLINK    = 2'd1;
  localparam logic [1:0]  FLASH_BREATHE  = 2'd2;
  localparam logic [31:0] RGB_MASK       = 32'h00ffffff;
  localparam logic [19:0] DIV_BASE       = 20'd255;

  localparam logic [7:0]  COEF_R = 8'd77;
  localparam logic [7:0]  COEF_G = 8'd150;
  localparam logic [7:0]  COEF_B = 8'd29;

endpackage

// File: hdl/ila_in_if.sv
// input channel of the indicator light arbiter: valid, ready and request payload
// no dependencies
interface ila_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  light_type;
  logic [31:0] color;
  logic [1:0]  flash_mode;
  logic [15:0] flash_on_ms;
  logic [15:0] flash_off_ms;
  logic [1:0]  brightness_mode;

  modport source (
    output valid, light_type, color, flash_mode, flash_on_ms, flash_off_ms,
           brightness_mode,
    input  ready
  );
  modport sink (
    input  valid, light_type, color, flash_mode, flash_on_ms, flash_off_ms,
           brightness_mode,
    output ready
  );
endinterface

// File: hdl/ila_out_if.sv
// result channel of the indicator light arbiter: valid, ready and drive settings
// no dependencies
interface ila_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        apply;
  logic        target;
  logic        levels_valid;
  logic [11:0] backlight_level;
  logic [7:0]  white_level;
  logic [7:0]  blue_level;
  logic [7:0]  green_level;
  logic        breathe;
  logic [15:0] delay_on_ms;
  logic [15:0] delay_off_ms;

  modport source (
    output valid, status, apply, target, levels_valid, backlight_level,
           white_level, blue_level, green_level, breathe, delay_on_ms,
           delay_off_ms,
    input  ready
  );
  modport sink (
    input  valid, status, apply, target, levels_valid, backlight_level,
           white_level, blue_level, green_level, breathe, delay_on_ms,
           delay_off_ms,
    output ready
  );
endinterface

// File: hdl/ila_mul_unit.sv
// shared 8x12 multiplier with optional floor divide by 255; product and result are registered
// depends on ila_pkg
module ila_mul_unit
  import ila_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  ila_mul_req_t req,
  output ila_mul_rsp_t rsp
);

  logic [19:0] prod_r;
  logic        div_r;
  logic        v1_r;
  logic        v2_r;
  logic [19:0] res_r;

  logic [27:0] recip;
  logic [11:0] q0;
  logic [19:0] back;
  logic [19:0] rem;
  logic [11:0] quot;

  // p/255 estimated as p*257 >> 16, low by at most one
  always_comb begin
    recip = {8'b0, prod_r} + {prod_r, 8'b0};
    q0    = recip[27:16];
    back  = {q0, 8'b0} - {8'b0, q0};
    rem   = prod_r - back;
    quot  = (rem >= DIV_BASE) ? q0 + 12'd1 : q0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req.start;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod_r <= {12'b0, req.op_a} * {8'b0, req.op_b};
      div_r  <= req.div_en;
    end
    if (v1_r) begin
      res_r <= div_r ? {8'b0, quot} : prod_r;
    end
  end

  assign rsp.done   = v2_r;
  assign rsp.result = res_r;

endmodule

// File: hdl/ila_store.sv
// four stored light requests and the priority pick of the effective one
// depends on ila_pkg
module ila_store
  import ila_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  logic [1:0] wr_idx,
  input  ila_req_t wr_req,
  input  logic     grp_bl,
  output ila_req_t eff
);

  ila_req_t ent_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        ent_r[i] <= '0;
      end
    end else if (wr_en) begin
      ent_r[wr_idx] <= wr_req;
    end
  end

  // backlight group: its own entry; indicator group: first lit entry, else its last entry
  always_comb begin
    priority if (grp_bl) begin
      eff = ent_r[3];
    end else if ((ent_r[0].color & RGB_MASK) != 32'd0) begin
      eff = ent_r[0];
    end else if ((ent_r[1].color & RGB_MASK) != 32'd0) begin
      eff = ent_r[1];
    end else begin
      eff = ent_r[2];
    end
  end

endmodule

// File: hdl/indicator_light_arbiter.sv
// indicator light arbiter top level: sequencer, config registers, output register
// depends on ila_pkg, ila_in_if, ila_out_if, ila_store, ila_mul_unit
// sequence: an unsupported type goes from accept straight to the output state; unchanged, blink or breathing
//   results pass the store write and compare first; a steady indicator change runs 9 shared-unit operations,
//   a backlight change runs 7, each an issue and a wait on the 2-stage multiply/divide unit
// throughput: one transaction at a time, ready only while idle
// reset: synchronous active-low rst_n clears stored requests, maxima to 255
module indicator_light_arbiter
  import ila_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ila_in_if.sink      in_ch,
  ila_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BEFORE = 3'd1;
  localparam logic [2:0] S_AFTER  = 3'd2;
  localparam logic [2:0] S_ISSUE  = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  // shared-unit operation sequence
  localparam logic [3:0] OP_SCALE_R   = 4'd0;
  localparam logic [3:0] OP_SCALE_G   = 4'd1;
  localparam logic [3:0] OP_SCALE_B   = 4'd2;
  localparam logic [3:0] OP_LUMA_R    = 4'd3;
  localparam logic [3:0] OP_LUMA_G    = 4'd4;
  localparam logic [3:0] OP_LUMA_B    = 4'd5;
  localparam logic [3:0] OP_LVL_FIRST = 4'd6;
  localparam logic [3:0] OP_LVL_BLUE  = 4'd7;
  localparam logic [3:0] OP_LVL_GREEN = 4'd8;

  // config register indexes
  localparam logic [1:0] REG_BACKLIGHT_MAX = 2'd0;
  localparam logic [1:0] REG_WHITE_MAX     = 2'd1;
  localparam logic [1:0] REG_BLUE_MAX      = 2'd2;
  localparam logic [1:0] REG_GREEN_MAX     = 2'd3;

  logic [2:0]   state_r;
  logic [2:0]   state_nxt;
  logic [2:0]   type_r;
  ila_req_t     req_r;
  ila_req_t     before_r;
  logic [31:0]  color_r;
  logic [3:0]   op_r;
  logic [7:0]   ch_r [3];
  logic [15:0]  acc_r;
  ila_res_t     res_r;
  ila_res_t     out_r;
  logic         out_valid_r;

  logic [11:0]  backlight_max_r;
  logic [7:0]   white_max_r;
  logic [7:0]   blue_max_r;
  logic [7:0]   green_max_r;

  ila_req_t     eff;
  ila_mul_req_t mul_req;
  ila_mul_rsp_t mul_rsp;
  logic         is_bl;
  logic [3:0]   last_op;
  logic         out_free;
  logic         cfg_wr;

  assign is_bl    = (type_r == {1'b0, TYPE_BACKLIGHT});
  assign last_op  = is_bl ? OP_LVL_FIRST : OP_LVL_GREEN;
  assign out_free = !out_valid_r || out_ch.ready;

  // request store, written once per supported transaction
  ila_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (state_r == S_BEFORE),
    .wr_idx (type_r[1:0]),
    .wr_req (req_r),
    .grp_bl (is_bl),
    .eff    (eff)
  );

  ila_mul_unit u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // operand select for the current operation
  always_comb begin
    mul_req.start = (state_r == S_ISSUE);
    case (op_r)
      OP_SCALE_R: begin
        mul_req.op_a = color_r[23:16];
        mul_req.op_b = {4'b0, color_r[31:24]};
        mul_req.div_en = 1'b1;
      end
      OP_SCALE_G: begin
        mul_req.op_a = color_r[15:8];
        mul_req.op_b = {4'b0, color_r[31:24]};
        mul_req.div_en = 1'b1;
      end
      OP_SCALE_B: begin
        mul_req.op_a = color_r[7:0];
        mul_req.op_b = {4'b0, color_r[31:24]};
        mul_req.div_en = 1'b1;
      end
      OP_LUMA_R: begin
        mul_req.op_a = ch_r[0];
        mul_req.op_b = {4'b0, COEF_R};
        mul_req.div_en = 1'b0;
      end
      OP_LUMA_G: begin
        mul_req.op_a = ch_r[1];
        mul_req.op_b = {4'b0, COEF_G};
        mul_req.div_en = 1'b0;
      end
      OP_LUMA_B: begin
        mul_req.op_a = ch_r[2];
        mul_req.op_b = {4'b0, COEF_B};
        mul_req.div_en = 1'b0;
      end
      // luma is the top byte of the weighted sum
      OP_LVL_FIRST: begin
        mul_req.op_a = acc_r[15:8];
        mul_req.op_b = is_bl ? backlight_max_r : {4'b0, white_max_r};
        mul_req.div_en = 1'b1;
      end
      OP_LVL_BLUE: begin
        mul_req.op_a = acc_r[15:8];
        mul_req.op_b = {4'b0, blue_max_r};
        mul_req.div_en = 1'b1;
      end
      OP_LVL_GREEN: begin
        mul_req.op_a = acc_r[15:8];
        mul_req.op_b = {4'b0, green_max_r};
        mul_req.div_en = 1'b1;
      end
      default: begin
        mul_req.op_a = 8'd0;
        mul_req.op_b = 12'd0;
        mul_req.div_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ch.light_type[2] ? S_OUT : S_BEFORE;
        end
      end
      S_BEFORE: begin
        state_nxt = S_AFTER;
      end
      S_AFTER: begin
        // unchanged results and indicator blink and breathing results need no arithmetic
        priority if (eff == before_r) begin
          state_nxt = S_OUT;
        end else if (is_bl) begin
          state_nxt = S_ISSUE;
        end else if (eff.mode == FLASH_BREATHE || eff.mode == FLASH_BLINK) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = (op_r == last_op) ? S_OUT : S_ISSUE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_SCALE_R;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_AFTER) begin
        op_r <= OP_SCALE_R;
      end else if (state_r == S_WAIT && mul_rsp.done) begin
        op_r <= op_r + 4'd1;
      end
    end
  end

  // transaction data path
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          type_r       <= in_ch.light_type;
          req_r.color  <= in_ch.color;
          req_r.mode   <= in_ch.flash_mode;
          req_r.on_ms  <= in_ch.flash_on_ms;
          req_r.off_ms <= in_ch.flash_off_ms;
          req_r.bmode  <= in_ch.brightness_mode;
          res_r        <= '0;
          res_r.status <= in_ch.light_type[2];
        end
      end
      S_BEFORE: begin
        // store is written at this edge, pick still sees the old entries
        before_r <= eff;
      end
      S_AFTER: begin
        color_r <= eff.color;
        if (eff != before_r) begin
          res_r.apply <= 1'b1;
          priority if (is_bl) begin
            res_r.target       <= 1'b1;
            res_r.levels_valid <= 1'b1;
          end else if (eff.mode == FLASH_BREATHE) begin
            res_r.breathe <= 1'b1;
          end else if (eff.mode == FLASH_BLINK) begin
            res_r.delay_on_ms  <= eff.on_ms;
            res_r.delay_off_ms <= eff.off_ms;
          end else begin
            // steady, flash mode three drives as steady
            res_r.levels_valid <= 1'b1;
          end
        end
      end
      S_WAIT: begin
        if (mul_rsp.done) begin
          case (op_r)
            OP_SCALE_R: ch_r[0] <= mul_rsp.result[7:0];
            OP_SCALE_G: ch_r[1] <= mul_rsp.result[7:0];
            OP_SCALE_B: ch_r[2] <= mul_rsp.result[7:0];
            OP_LUMA_R:  acc_r <= mul_rsp.result[15:0];
            OP_LUMA_G:  acc_r <= acc_r + mul_rsp.result[15:0];
            OP_LUMA_B:  acc_r <= acc_r + mul_rsp.result[15:0];
            OP_LVL_FIRST: begin
              if (is_bl) begin
                res_r.backlight_level <= mul_rsp.result[11:0];
              end else begin
                res_r.white_level <= mul_rsp.result[7:0];
              end
            end
            OP_LVL_BLUE:  res_r.blue_level  <= mul_rsp.result[7:0];
            OP_LVL_GREEN: res_r.green_level <= mul_rsp.result[7:0];
            default: ;
          endcase
        end
      end
      S_ISSUE, S_OUT: ;
      default: ;
    endcase
  end

  // output register, parts the sequencer from the result sink
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
      out_r       <= res_r;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_r.status;
  assign out_ch.apply           = out_r.apply;
  assign out_ch.target          = out_r.target;
  assign out_ch.levels_valid    = out_r.levels_valid;
  assign out_ch.backlight_level = out_r.backlight_level;
  assign out_ch.white_level     = out_r.white_level;
  assign out_ch.blue_level      = out_r.blue_level;
  assign out_ch.green_level     = out_r.green_level;
  assign out_ch.breathe         = out_r.breathe;
  assign out_ch.delay_on_ms     = out_r.delay_on_ms;
  assign out_ch.delay_off_ms    = out_r.delay_off_ms;

  // config port, pready held high so an access never waits
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlight_max_r <= 12'd255;
      white_max_r     <= 8'd255;
      blue_max_r      <= 8'd255;
      green_max_r     <= 8'd255;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BACKLIGHT_MAX: backlight_max_r <= pwdata[11:0];
        REG_WHITE_MAX:     white_max_r     <= pwdata[7:0];
        REG_BLUE_MAX:      blue_max_r      <= pwdata[7:0];
        REG_GREEN_MAX:     green_max_r     <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BACKLIGHT_MAX: prdata = {20'b0, backlight_max_r};
      REG_WHITE_MAX:     prdata = {24'b0, white_max_r};
      REG_BLUE_MAX:      prdata = {24'b0, blue_max_r};
      REG_GREEN_MAX:     prdata = {24'b0, green_max_r};
    endcase
  end

  // shared unit answers only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> state_r == S_WAIT)
    else $error("shared unit result outside wait state");

  a_issue_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ISSUE |=> state_r == S_WAIT && !mul_rsp.done)
    else $error("issue not followed by a wait cycle");

  a_unsupported_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status |-> !out_r.apply && !out_r.levels_valid)
    else $error("unsupported type result carries drive settings");

  a_levels_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.levels_valid |-> !out_r.breathe && out_r.delay_on_ms == 16'd0)
    else $error("levels combined with blink or breathing");

endmodule
